[src/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the wait queue checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TWQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twq: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define TWQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twq: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define TWQ_ASSERT_NXT_NORST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("twq: next-cycle check across reset failed");

`endif

[src/twq_pkg.sv]
// ============================================================================
// Wait queue package
// Codes, widths and shared types of the thread wait queue.
// ============================================================================
package twq_pkg;

   localparam int ACTION_WIDTH  = 3;
   localparam int ID_PORT_WIDTH = 16;
   localparam int WAIT_WIDTH    = 16;
   localparam int STATUS_WIDTH  = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_PUT    = 3'd0,
      ACT_GET    = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_FIND   = 3'd3,
      ACT_TICK   = 3'd4
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_WALK,
      CS_FLUSH
   } ctrl_state_type;

   // What the sequencer tells the entry unit about the entry under work.
   typedef struct packed {
      action_type op;
      logic       is_head;
      logic       found;
   } walk_ctx_type;

   // What the entry unit decides for that entry.
   typedef struct packed {
      logic                  drop;
      logic                  expire;
      logic                  take;
      logic [WAIT_WIDTH-1:0] wait_next;
   } verdict_type;

endpackage

[src/twq_req_if.sv]
// ============================================================================
// Request channel
// Valid/ready channel that carries one queue operation per beat.
// ============================================================================
interface twq_req_if import twq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ACTION_WIDTH-1:0]  action;
   logic [ID_PORT_WIDTH-1:0] thread_id;
   logic [WAIT_WIDTH-1:0]    wait_ticks;

   modport source (output valid, action, thread_id, wait_ticks, input ready);
   modport sink   (input valid, action, thread_id, wait_ticks, output ready);
endinterface

[src/twq_rsp_if.sv]
// ============================================================================
// Response channel
// Valid/ready channel that carries one result per beat.
// ============================================================================
interface twq_rsp_if import twq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ID_PORT_WIDTH-1:0] result_id;
   logic [STATUS_WIDTH-1:0]  status;
   logic                     last_result;

   modport source (output valid, result_id, status, last_result, input ready);
   modport sink   (input valid, result_id, status, last_result, output ready);
endinterface

[src/thread_wait_queue_with_timeouts_top.sv]
// ============================================================================
// Thread wait queue with timeouts
// Bounded FIFO of thread ids with per-entry timeouts, search and delete.
// ============================================================================
//
//   Channel   Direction  Beat carries
//   req_if    in         action, thread_id, wait_ticks
//   rsp_if    out        result_id, status, last_result
//
// A put goes from acceptance to the closing flush state and back to ready.
// Get, remove, find and tick walk every stored entry before that closing
// state; the single read and write port of the entry RAM lets one entry pass
// the entry unit per cycle, unless a stalled response channel holds the walk.
// A tick on an empty queue and an unused action code return to ready at once.
// Reset is synchronous and empties the queue; the RAM itself is not cleared.
// A stalled response channel holds the walk only when a second expired entry
// has to leave while the result register is still occupied. The closing
// cycle of an operation that answers also waits until that register is free.
//
// Each get, remove, find and tick is a single walk over the RAM from the
// head. The read pointer runs ahead of the write pointer by the entries
// dropped so far, so kept entries are written back in place or lower and
// the gap is closed in the same pass. Get drops the head, remove drops the
// first match, tick drops every entry whose wait reaches zero.
//
// The last result of an operation is not known to be last until the walk
// ends, so the latest result is parked in a holding register. An expiring
// entry pushes the parked one out with last_result low; the closing cycle
// sends whatever is parked with last_result high.
//
module thread_wait_queue_with_timeouts_top import twq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic      clock,
   input  logic      reset,
   twq_req_if.sink   req_if,
   twq_rsp_if.source rsp_if
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = ID_WIDTH + WAIT_WIDTH;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   walk_ctx_type        walk_ctx;
   logic [ID_WIDTH-1:0] walk_key;
   verdict_type         verdict;

   // Each entry is stored as one word: id in the upper bits, wait below.
   twq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   twq_entry_unit #(
      .ID_WIDTH (ID_WIDTH)
   ) u_entry_unit (
      .ctx      (walk_ctx),
      .key      (walk_key),
      .ent_id   (ram_rdata[ENTRY_W-1:WAIT_WIDTH]),
      .ent_wait (ram_rdata[WAIT_WIDTH-1:0]),
      .verdict  (verdict)
   );

   twq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .walk_ctx  (walk_ctx),
      .walk_key  (walk_key),
      .verdict   (verdict)
   );

endmodule

[src/twq_ram.sv]
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
module twq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/twq_entry_unit.sv]
// ============================================================================
// Entry unit
// Shared compare and decrement logic applied to one queue entry per cycle.
// ============================================================================
module twq_entry_unit import twq_pkg::*; #(
   parameter int ID_WIDTH = 16
) (
   input  walk_ctx_type          ctx,
   input  logic [ID_WIDTH-1:0]   key,
   input  logic [ID_WIDTH-1:0]   ent_id,
   input  logic [WAIT_WIDTH-1:0] ent_wait,
   output verdict_type           verdict
);

   logic hit;

   assign hit = (ent_id == key);

   always_comb begin
      verdict           = '0;
      verdict.wait_next = ent_wait;
      unique case (ctx.op)
         ACT_GET: begin
            verdict.drop = ctx.is_head;
            verdict.take = ctx.is_head;
         end
         ACT_REMOVE: begin
            verdict.drop = hit && !ctx.found;
            verdict.take = hit && !ctx.found;
         end
         ACT_FIND: begin
            verdict.take = hit && !ctx.found;
         end
         ACT_TICK: begin
            // A zero wait never expires and is left as it is.
            if (ent_wait != '0) begin
               verdict.wait_next = ent_wait - WAIT_WIDTH'(1);
            end
            verdict.expire = (ent_wait == WAIT_WIDTH'(1));
            verdict.drop   = (ent_wait == WAIT_WIDTH'(1));
         end
         default: begin
            verdict.drop = 1'b0;
         end
      endcase
   end

endmodule

[src/twq_ctrl.sv]
// ============================================================================
// Wait queue sequencer
// Walks entries one slot per cycle unless stalled, compacts, drives results.
// ============================================================================
module twq_ctrl import twq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   twq_req_if.sink                             req_if,
   twq_rsp_if.source                           rsp_if,
   output logic                                ram_we,
   output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_waddr,
   output logic [ID_WIDTH+WAIT_WIDTH-1:0]      ram_wdata,
   output logic                                ram_re,
   output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_raddr,
   input  logic [ID_WIDTH+WAIT_WIDTH-1:0]      ram_rdata,
   output walk_ctx_type                        walk_ctx,
   output logic [ID_WIDTH-1:0]                 walk_key,
   input  verdict_type                         verdict
);

   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int ID_KEEP = (ID_WIDTH < ID_PORT_WIDTH) ? ID_WIDTH : ID_PORT_WIDTH;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   ctrl_state_type           state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_ff, rd_in;
   logic [CNT_W-1:0]         wr_ff, wr_in;
   action_type               op_ff, op_in;
   logic [ID_WIDTH-1:0]      key_ff, key_in;
   logic                     found_ff, found_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [ID_WIDTH-1:0]      pend_id_ff, pend_id_in;
   status_type               pend_status_ff, pend_status_in;
   logic                     out_valid_ff, out_valid_in;
   logic [ID_PORT_WIDTH-1:0] out_id_ff, out_id_in;
   status_type               out_status_ff, out_status_in;
   logic                     out_last_ff, out_last_in;

   logic [ID_WIDTH-1:0]      req_key;
   logic [ID_WIDTH-1:0]      ent_id;
   logic [CNT_W-1:0]         rd_next;
   logic [CNT_W-1:0]         wr_next;
   logic                     out_free;
   action_type               req_action;

   assign req_key    = ID_WIDTH'(req_if.thread_id[ID_KEEP-1:0]);
   assign req_action = action_type'(req_if.action);
   assign ent_id     = ram_rdata[ID_WIDTH+WAIT_WIDTH-1:WAIT_WIDTH];
   assign rd_next    = rd_ff + CNT_W'(1);
   assign out_free   = !out_valid_ff || rsp_if.ready;

   assign walk_ctx.op      = op_ff;
   assign walk_ctx.is_head = (rd_ff == '0);
   assign walk_ctx.found   = found_ff;
   assign walk_key         = key_ff;

   assign req_if.ready       = (state_ff == CS_IDLE);
   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_id   = out_id_ff;
   assign rsp_if.status      = out_status_ff;
   assign rsp_if.last_result = out_last_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      found_in       = found_ff;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff && !rsp_if.ready;
      out_id_in      = out_id_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      wr_next        = wr_ff;
      ram_we         = 1'b0;
      ram_waddr      = count_ff[IDX_W-1:0];
      ram_wdata      = {req_key, req_if.wait_ticks};
      ram_re         = 1'b0;
      ram_raddr      = '0;

      unique case (state_ff)
         CS_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_action;
               key_in   = req_key;
               found_in = 1'b0;
               rd_in    = '0;
               wr_in    = '0;
               pend_id_in = '0;
               unique case (req_action)
                  ACT_PUT: begin
                     pend_valid_in = 1'b1;
                     if (count_ff == DEPTH_CNT) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        ram_we         = 1'b1;
                        count_in       = count_ff + CNT_W'(1);
                        pend_status_in = ST_OK;
                     end
                     state_in = CS_FLUSH;
                  end
                  ACT_GET, ACT_REMOVE, ACT_FIND: begin
                     pend_valid_in  = 1'b1;
                     pend_status_in = (req_action == ACT_GET) ? ST_EMPTY : ST_NOT_FOUND;
                     if (count_ff == '0) begin
                        state_in = CS_FLUSH;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = CS_WALK;
                     end
                  end
                  ACT_TICK: begin
                     pend_valid_in = 1'b0;
                     if (count_ff != '0) begin
                        ram_re   = 1'b1;
                        state_in = CS_WALK;
                     end
                  end
                  default: begin
                     state_in = CS_IDLE;
                  end
               endcase
            end
         end
         CS_WALK: begin
            ram_waddr = wr_ff[IDX_W-1:0];
            ram_wdata = {ent_id, verdict.wait_next};
            // An expiry must first move the previous one out of the holding
            // register, so it waits while the result register is occupied.
            if (!(verdict.expire && pend_valid_ff && !out_free)) begin
               ram_we  = !verdict.drop;
               wr_next = verdict.drop ? wr_ff : wr_ff + CNT_W'(1);
               wr_in   = wr_next;
               if (verdict.expire) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_id_in     = ID_PORT_WIDTH'(pend_id_ff);
                     out_status_in = pend_status_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_id_in     = ent_id;
                  pend_status_in = ST_OK;
               end
               if (verdict.take) begin
                  found_in       = 1'b1;
                  pend_id_in     = ent_id;
                  pend_status_in = ST_OK;
               end
               if (rd_next < count_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = rd_next[IDX_W-1:0];
                  rd_in     = rd_next;
               end else begin
                  count_in = wr_next;
                  state_in = CS_FLUSH;
               end
            end
         end
         CS_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = CS_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_id_in     = ID_PORT_WIDTH'(pend_id_ff);
               out_status_in = pend_status_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CS_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff          <= rd_in;
      wr_ff          <= wr_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      found_ff       <= found_in;
      pend_id_ff     <= pend_id_in;
      pend_status_ff <= pend_status_in;
      out_id_ff      <= out_id_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

endmodule

[src/twq_checker.sv]
// ============================================================================
// Wait queue checker
// Port-level assertions on the wait queue, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module twq_checker import twq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [ACTION_WIDTH-1:0]  req_action,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [ID_PORT_WIDTH-1:0] rsp_result_id,
   input logic [STATUS_WIDTH-1:0]  rsp_status,
   input logic                     rsp_last_result
);

   // A result beat that is not taken stays in place unchanged.
   `TWQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_id) && $stable(rsp_status) && $stable(rsp_last_result))

   // Error results carry no id and always close their operation.
   `TWQ_ASSERT_IMP(a_err_no_id, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_result_id == '0)
   `TWQ_ASSERT_IMP(a_err_last, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_last_result)

   // The block comes out of reset ready for work.
   `TWQ_ASSERT_NXT_NORST(a_reset_ready, clock, reset, req_ready)

   // Every operation that answers keeps the block busy after its acceptance.
   `TWQ_ASSERT_NXT(a_busy_after_op, clock, reset, req_valid && req_ready && (req_action == ACT_PUT || req_action == ACT_GET || req_action == ACT_REMOVE || req_action == ACT_FIND), !req_ready)

endmodule

bind thread_wait_queue_with_timeouts_top twq_checker u_twq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_action      (req_if.action),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_result_id   (rsp_if.result_id),
   .rsp_status      (rsp_if.status),
   .rsp_last_result (rsp_if.last_result)
);

[tb/tb_thread_wait_queue_with_timeouts_top.sv]
// ============================================================================
// Thread wait queue testbench
// Drives put, get, remove, find and tick beats into the wait queue with random
// gaps and response stalls. A shadow copy of the queue predicts every result,
// and each response beat is checked in order against that prediction.
// ============================================================================
`timescale 1ns / 100ps

module tb_thread_wait_queue_with_timeouts_top;
   import twq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_WIDTH     = 16;
   localparam int RANDOM_ITEMS = 205;
   localparam int MAX_IDLE     = 8;
   // Drain time after the last expected beat, so that any stray response still
   // shows up.
   localparam int DRAIN_CYCLES = 4 * (QUEUE_DEPTH + 2);

   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED_LAST  = 3'd7;

   localparam logic [ID_PORT_WIDTH-1:0] ID_MASK =
      ID_PORT_WIDTH'((64'd1 << ID_WIDTH) - 64'd1);

   typedef struct {
      logic [ID_PORT_WIDTH-1:0] id;
      status_type               status;
      logic                     last;
   } wait_result_type;

   // Shadow of the wait queue. It replays every accepted request beat on its
   // own copy of the entries and keeps the results that the block owes.
   class wait_queue_shadow;
      logic [ID_PORT_WIDTH-1:0] ids[QUEUE_DEPTH];
      logic [WAIT_WIDTH-1:0]    waits[QUEUE_DEPTH];
      int                       count;
      wait_result_type          pending_results[$];
      int errors, checked;
      int n_put, n_full, n_get, n_empty, n_search, n_hit;
      int n_tick, n_expired, max_expired;

      function new();
         count = 0;
         errors = 0;
         checked = 0;
         n_put = 0;
         n_full = 0;
         n_get = 0;
         n_empty = 0;
         n_search = 0;
         n_hit = 0;
         n_tick = 0;
         n_expired = 0;
         max_expired = 0;
      endfunction

      function void push_result(logic [ID_PORT_WIDTH-1:0] id, status_type status,
                                logic last);
         wait_result_type r;
         r.id = id;
         r.status = status;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      // Remove one slot and pull the entries behind it forward.
      function void drop_slot(int pos);
         for (int i = pos; i + 1 < count; i++) begin
            ids[i] = ids[i + 1];
            waits[i] = waits[i + 1];
         end
         if (count > 0)
            count--;
      endfunction

      function int find_slot(logic [ID_PORT_WIDTH-1:0] key);
         for (int i = 0; i < count; i++)
            if (ids[i] == key)
               return i;
         return -1;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function void accept_request(logic [ACTION_WIDTH-1:0] act,
                                   logic [ID_PORT_WIDTH-1:0] tid,
                                   logic [WAIT_WIDTH-1:0] ticks);
         logic [ID_PORT_WIDTH-1:0] key;
         logic [ID_PORT_WIDTH-1:0] gone[$];
         int pos;
         int i;
         key = tid & ID_MASK;
         case (act)
            ACT_PUT: begin
               n_put++;
               if (count >= QUEUE_DEPTH) begin
                  n_full++;
                  push_result('0, ST_FULL, 1'b1);
               end else begin
                  ids[count] = key;
                  waits[count] = ticks;
                  count++;
                  push_result('0, ST_OK, 1'b1);
               end
            end
            ACT_GET: begin
               n_get++;
               if (count == 0) begin
                  n_empty++;
                  push_result('0, ST_EMPTY, 1'b1);
               end else begin
                  push_result(ids[0], ST_OK, 1'b1);
                  drop_slot(0);
               end
            end
            ACT_REMOVE, ACT_FIND: begin
               n_search++;
               pos = find_slot(key);
               if (pos < 0) begin
                  push_result('0, ST_NOT_FOUND, 1'b1);
               end else begin
                  n_hit++;
                  if (act == ACT_REMOVE)
                     drop_slot(pos);
                  push_result(key, ST_OK, 1'b1);
               end
            end
            ACT_TICK: begin
               n_tick++;
               i = 0;
               while (i < count) begin
                  if (waits[i] != '0) begin
                     waits[i] = waits[i] - 1'b1;
                     if (waits[i] == '0) begin
                        gone.push_back(ids[i]);
                        drop_slot(i);
                        continue;
                     end
                  end
                  i++;
               end
               for (int k = 0; k < gone.size(); k++)
                  push_result(gone[k], ST_OK, k == gone.size() - 1);
               n_expired += gone.size();
               if (gone.size() > max_expired)
                  max_expired = gone.size();
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [ID_PORT_WIDTH-1:0] got_id,
                                 logic [STATUS_WIDTH-1:0] got_status,
                                 logic got_last);
         wait_result_type exp;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t ERROR: result beat with none expected: id=%h status=%0d last=%0b",
                     $time, got_id, got_status, got_last);
            return;
         end
         exp = pending_results.pop_front();
         checked++;
         if (got_id !== exp.id) begin
            errors++;
            $display("%0t ERROR: result_id expected %h actual %h", $time, exp.id, got_id);
         end
         if (got_status !== exp.status) begin
            errors++;
            $display("%0t ERROR: status expected %0d actual %0d", $time, exp.status,
                     got_status);
         end
         if (got_last !== exp.last) begin
            errors++;
            $display("%0t ERROR: last_result expected %0b actual %0b", $time, exp.last,
                     got_last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   // While set, neither side inserts idle cycles, so back-to-back beats occur.
   logic no_idle;
   int   items_sent;
   int   directed_items;

   twq_req_if req_if();
   twq_rsp_if rsp_if();

   wait_queue_shadow board;

   thread_wait_queue_with_timeouts_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_WIDTH   (ID_WIDTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Ids mostly come from a small pool of sixteen values, so that searches and
   // removes hit and duplicates appear. The rest are fully random so that
   // every id bit toggles. The pool spans 0000 to FFFF.
   function automatic logic [ID_PORT_WIDTH-1:0] pick_id();
      if ($urandom_range(0, 9) < 7)
         return ID_PORT_WIDTH'($urandom_range(0, 15) * 16'h1111);
      return ID_PORT_WIDTH'($urandom);
   endfunction

   // Mostly short timeouts so that entries expire within the run, with some
   // entries that never expire and some with large random waits.
   function automatic logic [WAIT_WIDTH-1:0] pick_wait();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      if (r < 70)
         return WAIT_WIDTH'($urandom_range(1, 6));
      if (r < 85)
         return WAIT_WIDTH'($urandom_range(7, 40));
      return WAIT_WIDTH'($urandom);
   endfunction

   // Sends one request beat. Valid is only dropped when an idle gap precedes
   // the beat; with no gap the next beat follows in the step of acceptance.
   task automatic send_request(input logic [ACTION_WIDTH-1:0] act,
                               input logic [ID_PORT_WIDTH-1:0] tid,
                               input logic [WAIT_WIDTH-1:0] ticks);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.thread_id  <= tid;
      req_if.wait_ticks <= ticks;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.accept_request(act, tid, ticks);
      // Unused codes are ignored by the block and do not count as items.
      if (act <= ACT_TICK)
         items_sent++;
   endtask

   // Response side: after each accepted result beat, hold ready low for a
   // random number of cycles, then wait for the next beat.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   // Result monitor. Signals are read at the rising edge, before the
   // nonblocking updates of that edge, so they hold the beat being accepted.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_result(rsp_if.result_id, rsp_if.status, rsp_if.last_result);
   end

   // Main stimulus: reset, a directed pass, then random phases.
   initial begin
      logic [WAIT_WIDTH-1:0] fill_wait;
      int r;
      board = new();
      items_sent = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.action     <= ACT_PUT;
      req_if.thread_id  <= '0;
      req_if.wait_ticks <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Get, find, remove and tick on an empty queue first, then the
      // unused action codes, which must leave no trace.
      send_request(ACT_GET, 16'h0000, 16'h0000);
      send_request(ACT_FIND, 16'h0000, 16'hFFFF);
      send_request(ACT_REMOVE, 16'hFFFF, 16'h0000);
      send_request(ACT_TICK, 16'hFFFF, 16'hFFFF);
      for (int c = ACT_UNUSED_FIRST; c <= ACT_UNUSED_LAST; c++)
         send_request(ACTION_WIDTH'(c), pick_id(), pick_wait());

      // Extreme ids and waits, an entry with no timeout and a duplicate id.
      send_request(ACT_PUT, 16'h0000, 16'h0000);
      send_request(ACT_PUT, 16'hFFFF, 16'hFFFF);
      send_request(ACT_PUT, 16'h1234, 16'h0001);
      send_request(ACT_PUT, 16'h1234, 16'h0000);
      send_request(ACT_PUT, 16'h1234, 16'h0003);
      send_request(ACT_PUT, 16'h00FF, 16'h0001);
      send_request(ACT_FIND, 16'hFFFF, 16'h0000);
      send_request(ACT_FIND, 16'h0001, 16'h0000);

      // Two entries expire in one tick; the first 1234 goes, the others stay.
      send_request(ACT_TICK, 16'h0000, 16'h0000);
      // Remove must take only the first remaining 1234, the one that never
      // expires, so the later copy is still found afterwards.
      send_request(ACT_REMOVE, 16'h1234, 16'h0000);
      send_request(ACT_FIND, 16'h1234, 16'h0000);
      send_request(ACT_TICK, 16'h0000, 16'h0000);
      send_request(ACT_TICK, 16'h0000, 16'h0000);
      send_request(ACT_FIND, 16'h1234, 16'h0000);
      send_request(ACT_GET, 16'h0000, 16'h0000);
      send_request(ACT_GET, 16'h0000, 16'h0000);
      send_request(ACT_GET, 16'h0000, 16'h0000);
      directed_items = items_sent;

      // Random part, in phases. A fill phase optionally drains the queue,
      // fills it to the brim with mostly equal waits, overflows it once and
      // ticks until those entries leave together. A mixed phase throws
      // weighted random operations with random content.
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 1) == 1)
               while (board.count != 0)
                  send_request(ACT_GET, pick_id(), WAIT_WIDTH'($urandom));
            fill_wait = WAIT_WIDTH'($urandom_range(1, 4));
            while (board.count < QUEUE_DEPTH)
               send_request(ACT_PUT, pick_id(),
                            ($urandom_range(0, 3) == 0) ? pick_wait() : fill_wait);
            send_request(ACT_PUT, pick_id(), pick_wait());
            repeat (int'(fill_wait) + 1)
               send_request(ACT_TICK, ID_PORT_WIDTH'($urandom), WAIT_WIDTH'($urandom));
         end else begin
            repeat (15) begin
               r = $urandom_range(0, 99);
               if (r < 34)
                  send_request(ACT_PUT, pick_id(), pick_wait());
               else if (r < 46)
                  send_request(ACT_GET, pick_id(), WAIT_WIDTH'($urandom));
               else if (r < 60)
                  send_request(ACT_REMOVE, pick_id(), WAIT_WIDTH'($urandom));
               else if (r < 74)
                  send_request(ACT_FIND, pick_id(), WAIT_WIDTH'($urandom));
               else if (r < 94)
                  send_request(ACT_TICK, pick_id(), WAIT_WIDTH'($urandom));
               else
                  send_request(ACTION_WIDTH'($urandom_range(ACT_UNUSED_FIRST,
                                                            ACT_UNUSED_LAST)),
                               pick_id(), WAIT_WIDTH'($urandom));
            end
         end
      end
      req_if.valid <= 1'b0;
      no_idle = 1'b0;

      // Wait for every owed result, then a little longer for stray beats.
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d puts (%0d full), %0d gets (%0d empty), %0d searches (%0d hits).",
               board.n_put, board.n_full, board.n_get, board.n_empty, board.n_search,
               board.n_hit);
      $display("%0d ticks expired %0d entries, up to %0d in one tick; %0d beats checked.",
               board.n_tick, board.n_expired, board.max_expired, board.checked);
      if (board.errors == 0)
         $display("thread_wait_queue_with_timeouts_top: match");
      else
         $display("thread_wait_queue_with_timeouts_top: mismatch");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("thread_wait_queue_with_timeouts_top: mismatch");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/twq_pkg.sv
src/twq_req_if.sv
src/twq_rsp_if.sv
src/twq_ram.sv
src/twq_entry_unit.sv
src/twq_ctrl.sv
src/thread_wait_queue_with_timeouts_top.sv
src/twq_checker.sv
tb/tb_thread_wait_queue_with_timeouts_top.sv
